[sv/qcgs_pkg.sv]
// ----------------------------------------------------------------------------
// qcgs_pkg: shared types and constants of the crawl gait sequencer
// Field types, joint angle constants, register index codes and small helpers
// for joint slewing and arrival checks.
// ----------------------------------------------------------------------------
package qcgs_pkg;

    localparam int SAMPLE_W = 10;
    localparam int ANGLE_W  = 7;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 3;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [ANGLE_W-1:0]   angle_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [2:0]           phase_code_t;
    typedef logic [1:0]           leg_t;

    // Configuration register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_YAW       = 3'd0,
        CFG_CENTER_DRIVE     = 3'd1,
        CFG_CENTER_HEIGHT    = 3'd2,
        CFG_CENTER_AMPLITUDE = 3'd3,
        CFG_DEADZONE         = 3'd4,
        CFG_SLEW_STEP        = 3'd5,
        CFG_PHASE_TIMEOUT    = 3'd6,
        CFG_BALANCE_DROP     = 3'd7
    } cfg_idx_t;

    // Joint angle constants, degrees
    localparam angle_t HIP_REST   = 7'd90;
    localparam angle_t KNEE_REST  = 7'd45;
    localparam angle_t HIP_MIN    = 7'd60;
    localparam angle_t HIP_MAX    = 7'd120;
    localparam angle_t KNEE_MAX   = 7'd75;
    localparam angle_t SWING_MAX  = 7'd88;
    localparam angle_t SWING_LIFT = 7'd28;
    localparam angle_t SWING_MIN  = 7'd15;

    // Crawl order 0,2,1,3
    function automatic leg_t crawl_leg(input leg_t slot);
        leg_t leg;
        case (slot)
            2'd0:    leg = 2'd0;
            2'd1:    leg = 2'd2;
            2'd2:    leg = 2'd1;
            default: leg = 2'd3;
        endcase
        return leg;
    endfunction

    // Step a joint toward its target without overshoot
    function automatic angle_t slew_angle(input angle_t cur, input angle_t tgt,
                                          input logic [3:0] step);
        logic [ANGLE_W:0] up;
        logic [ANGLE_W:0] dn;
        angle_t           res;
        up  = {1'b0, cur} + {4'd0, step};
        dn  = {1'b0, cur} - {4'd0, step};
        res = cur;
        if (cur < tgt)
        begin
            res = (up > {1'b0, tgt}) ? tgt : up[ANGLE_W-1:0];
        end
        else if (cur > tgt)
        begin
            // dn wraps negative when step passes zero; treat that as overshoot
            res = (dn[ANGLE_W] || (dn < {1'b0, tgt})) ? tgt : dn[ANGLE_W-1:0];
        end
        return res;
    endfunction

    // Joint is within one step of its target
    function automatic logic angle_arrived(input angle_t cur, input angle_t tgt,
                                           input logic [3:0] step);
        angle_t diff;
        diff = (cur >= tgt) ? (cur - tgt) : (tgt - cur);
        return diff <= {3'd0, step};
    endfunction

endpackage

[sv/quadruped_crawl_gait_sequencer.sv]
// ----------------------------------------------------------------------------
// quadruped_crawl_gait_sequencer: joystick-driven crawl gait for four legs
// Turns four joystick samples per control tick into eight joint angles and
// the crawl phase, stepping one leg at a time through balance, lift, swing
// and plant.
// ----------------------------------------------------------------------------
// One control tick is one input transaction and gives one result transaction.
// The block takes a new tick every clock cycle: an input register captures
// the four samples, and one pass of combinational logic computes the gait
// targets, the phase step and the slew of all eight joints, which land in
// the state registers that also drive the result ports. Ticks pass the input
// register and then the state registers. The input stalls only while a result
// is waiting and the downstream side stalls. Configuration writes are always
// ready and must be issued while no tick is in flight.
// ----------------------------------------------------------------------------
module quadruped_crawl_gait_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  qcgs_pkg::cfg_data_t   cfg_data,

    // input tick channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  qcgs_pkg::sample_t     sample_yaw,
    input  qcgs_pkg::sample_t     sample_drive,
    input  qcgs_pkg::sample_t     sample_height,
    input  qcgs_pkg::sample_t     sample_amplitude,

    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output qcgs_pkg::angle_t      hip_angle_0,
    output qcgs_pkg::angle_t      hip_angle_1,
    output qcgs_pkg::angle_t      hip_angle_2,
    output qcgs_pkg::angle_t      hip_angle_3,
    output qcgs_pkg::angle_t      knee_angle_0,
    output qcgs_pkg::angle_t      knee_angle_1,
    output qcgs_pkg::angle_t      knee_angle_2,
    output qcgs_pkg::angle_t      knee_angle_3,
    output qcgs_pkg::phase_code_t gait_phase,
    output qcgs_pkg::leg_t        swing_leg
);

    import qcgs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BALANCE = 3'd1,
        PH_LIFT    = 3'd2,
        PH_SWING   = 3'd3,
        PH_PLANT   = 3'd4
    } phase_t;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    sample_t     center_yaw_reg;
    sample_t     center_drive_reg;
    sample_t     center_height_reg;
    sample_t     center_amplitude_reg;
    logic [8:0]  deadzone_reg;
    logic [3:0]  slew_step_reg;
    logic [9:0]  phase_timeout_reg;
    logic [6:0]  balance_drop_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_yaw_reg       <= 10'd512;
            center_drive_reg     <= 10'd512;
            center_height_reg    <= 10'd512;
            center_amplitude_reg <= 10'd512;
            deadzone_reg         <= 9'd35;
            slew_step_reg        <= 4'd2;
            phase_timeout_reg    <= 10'd280;
            balance_drop_reg     <= 7'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_YAW:       center_yaw_reg       <= cfg_data;
                CFG_CENTER_DRIVE:     center_drive_reg     <= cfg_data;
                CFG_CENTER_HEIGHT:    center_height_reg    <= cfg_data;
                CFG_CENTER_AMPLITUDE: center_amplitude_reg <= cfg_data;
                CFG_DEADZONE:         deadzone_reg         <= cfg_data[8:0];
                CFG_SLEW_STEP:        slew_step_reg        <= cfg_data[3:0];
                CFG_PHASE_TIMEOUT:    phase_timeout_reg    <= cfg_data;
                CFG_BALANCE_DROP:     balance_drop_reg     <= cfg_data[6:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake: the state registers double as the result register, so a
    // tick may only advance while the result slot is empty or being taken.
    // ------------------------------------------------------------------------
    logic    s1_valid_reg;
    sample_t s1_yaw_reg;
    sample_t s1_drive_reg;
    sample_t s1_height_reg;
    sample_t s1_amp_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    tick_fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign tick_fire = s1_valid_reg && advance;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Capture the samples of an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_yaw_reg    <= sample_yaw;
            s1_drive_reg  <= sample_drive;
            s1_height_reg <= sample_height;
            s1_amp_reg    <= sample_amplitude;
        end
    end

    // ------------------------------------------------------------------------
    // Joystick offsets and deadzone
    // ------------------------------------------------------------------------
    logic signed [10:0] yaw_raw;
    logic signed [10:0] drv_raw;
    logic signed [10:0] hgt;
    logic signed [10:0] ampl;
    logic signed [10:0] dz;
    logic               yaw_zero;
    logic               drv_zero;
    logic               yaw_pos;
    logic               drv_pos;
    logic               moving;

    assign yaw_raw = $signed({1'b0, s1_yaw_reg})    - $signed({1'b0, center_yaw_reg});
    assign drv_raw = $signed({1'b0, s1_drive_reg})  - $signed({1'b0, center_drive_reg});
    assign hgt     = $signed({1'b0, s1_height_reg}) - $signed({1'b0, center_height_reg});
    assign ampl    = $signed({1'b0, s1_amp_reg})    - $signed({1'b0, center_amplitude_reg});
    assign dz      = $signed({2'b00, deadzone_reg});

    // Zero offsets strictly inside the deadzone
    assign yaw_zero = (yaw_raw > -dz) && (yaw_raw < dz) || (yaw_raw == 11'sd0);
    assign drv_zero = (drv_raw > -dz) && (drv_raw < dz) || (drv_raw == 11'sd0);
    assign yaw_pos  = !yaw_zero && !yaw_raw[10];
    assign drv_pos  = !drv_zero && !drv_raw[10];
    assign moving   = !yaw_zero || !drv_zero;

    // ------------------------------------------------------------------------
    // Knee heights
    // ------------------------------------------------------------------------
    logic signed [15:0] hgt_prod;
    logic signed [15:0] hgt_quot;
    logic signed [15:0] ks_raw;
    angle_t             ks;

    assign hgt_prod = $signed({{5{hgt[10]}}, hgt}) * 16'sd30;
    // Divide by 512 truncating toward zero: bias negative values first
    assign hgt_quot = hgt_prod[15] ? ((hgt_prod + 16'sd511) >>> 9) : (hgt_prod >>> 9);
    assign ks_raw   = 16'sd45 + hgt_quot;
    assign ks       = ks_raw[15] ? 7'd0
                    : ((ks_raw > 16'sd75) ? KNEE_MAX : ks_raw[6:0]);

    // Amplitude clamped to 0..511, then scaled by 30/511 and 22/511.
    // x / 511 = q0 + (r >= 511) with q0 = x >> 9 and r = (x mod 512) + q0,
    // since r stays below twice the divisor.
    logic [8:0]  amp;
    logic [13:0] hip_x;
    logic [13:0] knee_x;
    logic [9:0]  hip_r;
    logic [9:0]  knee_r;
    logic [4:0]  hip_amp;
    logic [4:0]  knee_boost;

    assign amp     = ampl[10] ? 9'd0 : ((ampl > 11'sd511) ? 9'd511 : ampl[8:0]);
    assign hip_x   = 14'(amp) * 14'd30;
    assign knee_x  = 14'(amp) * 14'd22;
    assign hip_r   = {1'b0, hip_x[8:0]}  + {5'd0, hip_x[13:9]};
    assign knee_r  = {1'b0, knee_x[8:0]} + {5'd0, knee_x[13:9]};
    assign hip_amp    = hip_x[13:9]  + 5'(hip_r  >= 10'd511);
    assign knee_boost = knee_x[13:9] + 5'(knee_r >= 10'd511);

    logic [7:0] ksw_v;
    logic [7:0] ksw_lo;
    angle_t     ksw;
    angle_t     ks_stab;

    assign ksw_v   = {1'b0, ks} + {1'b0, SWING_LIFT} + {3'd0, knee_boost};
    assign ksw_lo  = {1'b0, ks} + {1'b0, SWING_MIN};
    assign ksw     = (ksw_v < ksw_lo) ? ksw_lo[6:0]
                   : ((ksw_v > {1'b0, SWING_MAX}) ? SWING_MAX : ksw_v[6:0]);
    // Saturate the support knee at zero for large drops
    assign ks_stab = (ks > balance_drop_reg) ? (ks - balance_drop_reg) : 7'd0;

    // ------------------------------------------------------------------------
    // Hip swing and push targets; legs 0 and 2 turn with positive side,
    // legs 1 and 3 with negative side.
    // ------------------------------------------------------------------------
    logic signed [8:0] fwd;
    logic signed [8:0] yo;
    angle_t            swing_hip [4];
    angle_t            push_hip  [4];

    assign fwd = drv_zero ? 9'sd0
               : (drv_pos ? $signed({4'd0, hip_amp}) : -$signed({4'd0, hip_amp}));
    assign yo  = yaw_zero ? 9'sd0
               : (yaw_pos ? $signed({5'd0, hip_amp[4:1]}) : -$signed({5'd0, hip_amp[4:1]}));

    always_comb
    begin
        logic signed [8:0] sw;
        logic signed [8:0] pu;
        for (int i = 0; i < 4; i++)
        begin
            if (i % 2 == 0)
            begin
                sw = 9'sd90 + fwd - yo;
                pu = 9'sd90 - fwd + yo;
            end
            else
            begin
                sw = 9'sd90 + fwd + yo;
                pu = 9'sd90 - fwd - yo;
            end
            swing_hip[i] = (sw < 9'sd60) ? HIP_MIN : ((sw > 9'sd120) ? HIP_MAX : sw[6:0]);
            push_hip[i]  = (pu < 9'sd60) ? HIP_MIN : ((pu > 9'sd120) ? HIP_MAX : pu[6:0]);
        end
    end

    // ------------------------------------------------------------------------
    // Gait state
    // ------------------------------------------------------------------------
    angle_t     cur_reg  [8];
    angle_t     tgt_reg  [8];
    phase_t     phase_reg;
    leg_t       slot_reg;
    logic [9:0] ticks_reg;

    angle_t     cur_next [8];
    angle_t     tgt_next [8];
    phase_t     phase_next;
    leg_t       slot_next;
    logic [9:0] ticks_next;
    leg_t       leg;
    logic [7:0] arr;

    assign leg = crawl_leg(slot_reg);

    // Rewrite the targets for this phase
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            tgt_next[j] = tgt_reg[j];
        end
        if (phase_reg inside {PH_BALANCE, PH_LIFT, PH_SWING, PH_PLANT})
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (!moving)
                begin
                    // Released stick: return to stance
                    tgt_next[i]     = HIP_REST;
                    tgt_next[i + 4] = ks;
                end
                else if (2'(i) == leg)
                begin
                    tgt_next[i]     = (phase_reg inside {PH_BALANCE, PH_LIFT}) ?
                                      HIP_REST : swing_hip[i];
                    tgt_next[i + 4] = (phase_reg inside {PH_BALANCE, PH_PLANT}) ?
                                      ks : ksw;
                end
                else
                begin
                    tgt_next[i]     = push_hip[i];
                    tgt_next[i + 4] = (phase_reg inside {PH_BALANCE, PH_LIFT}) ?
                                      ks_stab : ks;
                end
            end
        end
        else
        begin
            // Idle: knees follow the stance height, hips hold
            for (int i = 4; i < 8; i++)
            begin
                tgt_next[i] = ks;
            end
        end
    end

    // Arrival against the new targets, then slew every joint
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            arr[j]      = angle_arrived(cur_reg[j], tgt_next[j], slew_step_reg);
            cur_next[j] = slew_angle(cur_reg[j], tgt_next[j], slew_step_reg);
        end
    end

    // Phase sequencing with timeout
    always_comb
    begin
        logic       done;
        logic [9:0] ticks_inc;
        logic       sup_arr;
        phase_t     phase_adv;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        ticks_next = ticks_reg;
        ticks_inc  = ticks_reg + 10'd1;
        sup_arr    = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) != leg && !arr[i + 4])
            begin
                sup_arr = 1'b0;
            end
        end
        case (phase_reg)
            PH_BALANCE:
            begin
                done      = sup_arr;
                phase_adv = PH_LIFT;
            end
            PH_LIFT:
            begin
                done      = arr[{1'b1, leg}];
                phase_adv = PH_SWING;
            end
            PH_SWING:
            begin
                done      = arr[{1'b0, leg}];
                phase_adv = PH_PLANT;
            end
            PH_PLANT:
            begin
                done      = arr[{1'b1, leg}];
                phase_adv = PH_BALANCE;
            end
            default:
            begin
                done      = 1'b0;
                phase_adv = PH_BALANCE;
            end
        endcase

        if (phase_reg inside {PH_BALANCE, PH_LIFT, PH_SWING, PH_PLANT})
        begin
            if (!moving)
            begin
                phase_next = PH_IDLE;
            end
            else if (done || (ticks_inc >= phase_timeout_reg))
            begin
                ticks_next = 10'd0;
                phase_next = phase_adv;
                if (phase_reg == PH_PLANT)
                begin
                    slot_next = slot_reg + 2'd1;
                end
            end
            else
            begin
                ticks_next = ticks_inc;
            end
        end
        else
        begin
            phase_next = PH_IDLE;
            if (moving)
            begin
                ticks_next = 10'd0;
                phase_next = PH_BALANCE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cur_reg[i]     <= HIP_REST;
                tgt_reg[i]     <= HIP_REST;
                cur_reg[i + 4] <= KNEE_REST;
                tgt_reg[i + 4] <= KNEE_REST;
            end
            phase_reg <= PH_IDLE;
            slot_reg  <= 2'd0;
            ticks_reg <= 10'd0;
        end
        else if (tick_fire)
        begin
            for (int j = 0; j < 8; j++)
            begin
                cur_reg[j] <= cur_next[j];
                tgt_reg[j] <= tgt_next[j];
            end
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            ticks_reg <= ticks_next;
        end
    end

    // Result ports come straight from the state, which holds while stalled
    assign hip_angle_0  = cur_reg[0];
    assign hip_angle_1  = cur_reg[1];
    assign hip_angle_2  = cur_reg[2];
    assign hip_angle_3  = cur_reg[3];
    assign knee_angle_0 = cur_reg[4];
    assign knee_angle_1 = cur_reg[5];
    assign knee_angle_2 = cur_reg[6];
    assign knee_angle_3 = cur_reg[7];
    assign gait_phase   = phase_reg;
    assign swing_leg    = crawl_leg(slot_reg);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The input side stalls only behind a waiting, stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // Every valid joint angle, knees included, stays at or below the hip maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hip_angle_0 <= HIP_MAX && hip_angle_1 <= HIP_MAX &&
                       hip_angle_2 <= HIP_MAX && hip_angle_3 <= HIP_MAX &&
                       knee_angle_0 <= HIP_MAX && knee_angle_1 <= HIP_MAX &&
                       knee_angle_2 <= HIP_MAX && knee_angle_3 <= HIP_MAX))
        else $error("joint angle out of range");

    // Lift only holds, moves on to swing, or drops to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LIFT |=>
            (phase_reg == PH_LIFT || phase_reg == PH_SWING || phase_reg == PH_IDLE))
        else $error("illegal exit from lift phase");

    // The crawl order advances only on leaving the plant phase
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg != $past(slot_reg) |-> $past(phase_reg) == PH_PLANT)
        else $error("crawl slot moved outside plant phase");

endmodule
